// ===== rtl/rmes_pkg.sv =====
// Shared types and constants of the rotated midpoint ellipse stepper.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rmes_pkg;

   // Default sizes handed down from the top level.
   localparam int COORD_BITS_DEFAULT    = 12;
   localparam int RADIUS_BITS_DEFAULT   = 11;
   localparam int MAX_PEN_WIDTH_DEFAULT = 16;

   // Configuration port geometry and register reset values.
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int TRIG_BITS      = 16;
   localparam int PEN_BITS       = 5;
   localparam int COPY_BITS      = 4;
   localparam logic signed [TRIG_BITS-1:0] COS_RESET = 16'sh4000;
   localparam logic signed [TRIG_BITS-1:0] SIN_RESET = 16'sh0000;
   localparam logic [PEN_BITS-1:0]         PEN_RESET = 5'd1;

   // Q1.14 rotation: fraction bits and the one half added before the floor.
   localparam int FRAC_BITS  = 14;
   localparam int ROUND_HALF = 8192;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_RADIUS_X  = 3'd2,
      CSR_RADIUS_Y  = 3'd3,
      CSR_COS_Q14   = 3'd4,
      CSR_SIN_Q14   = 3'd5,
      CSR_PEN_WIDTH = 3'd6
   } csr_index_type;

   // Drawing phase of the current ellipse.
   typedef enum logic [1:0] {
      PH_DONE,
      PH_R1,
      PH_R2
   } phase_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_PROD,
      ST_INIT_DEC,
      ST_R1_DEC,
      ST_R2_DEC,
      ST_SETTLE,
      ST_SQ,
      ST_PROD2,
      ST_DEC2,
      ST_ROT,
      ST_MIRROR,
      ST_COPY
   } state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_INIT_PROD,
      OP_INIT_DEC,
      OP_R1_MOVE,
      OP_R1_DEC,
      OP_R2_MOVE,
      OP_R2_DEC,
      OP_SQ,
      OP_PROD2,
      OP_DEC2,
      OP_ROT,
      OP_MIRROR,
      OP_LOAD_OUT
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [1:0]           mirror;
      logic [COPY_BITS-1:0] copy;
      logic                 last;
      logic                 done;
   } cmd_type;

   typedef struct packed {
      logic px_lt_py;
      logic y_pos;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/rmes_if.sv =====
// Handshake interfaces of the ellipse stepper: request words and pixel words.
// Depends on rmes_pkg for the default coordinate width.
interface rmes_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rmes_rsp_if #(
   parameter int COORD_BITS = rmes_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_of_step;
   logic                  ellipse_done;

   modport source (output valid, output pixel_x, output pixel_y, output last_of_step,
                   output ellipse_done, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input last_of_step,
                 input ellipse_done, output ready);
endinterface

// ===== rtl/rotated_midpoint_ellipse_stepper.sv =====
// Rotated midpoint ellipse stepper: a request word with restart = 1 starts an ellipse
// at (0, ry); each request word with restart = 0 runs one midpoint iteration.
// Each iteration's point gives four mirrored pixels, each rotated about the centre by
// the Q1.14 cosine and sine, rounded half up, and drawn pen_width times on a
// diagonal (zero as one, at most MAX_PEN_WIDTH); every copy is clamped to the screen and leaves as one response word.
// The last word of an item carries last_of_step; ellipse_done marks the final point.
// A step after the final point gives no words.
// Steps per item: acceptance, then iteration (INIT_PROD, INIT_DEC and SETTLE on a
// restart; R1_DEC and SETTLE on a region 1 step; R2_DEC on a region 2 step),
// SQ, PROD2 and DEC2 when region 2 is entered, rotation, and per quadrant a setup
// then the output words, one word per cycle while the output register is free.
// A new request is taken once the last word sits in the output register.
// Reset is synchronous: registers return to their reset values and the stepper waits
// for a restart. A stalled receiver holds the output register and the sequencer.
// Depends on rmes_pkg, rmes_if, rmes_ctrl and rmes_dp.
module rotated_midpoint_ellipse_stepper #(
   parameter int COORD_BITS    = rmes_pkg::COORD_BITS_DEFAULT,
   parameter int RADIUS_BITS   = rmes_pkg::RADIUS_BITS_DEFAULT,
   parameter int MAX_PEN_WIDTH = rmes_pkg::MAX_PEN_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rmes_req_if.sink                            req,
   rmes_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [rmes_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmes_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [COORD_BITS-1:0]                 center_x_ff, center_y_ff;
   logic [RADIUS_BITS-1:0]                radius_x_ff, radius_y_ff;
   logic signed [rmes_pkg::TRIG_BITS-1:0] cos_ff, sin_ff;
   logic [rmes_pkg::PEN_BITS-1:0]         pen_ff;

   rmes_pkg::cmd_type    cmd;
   rmes_pkg::status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_x_ff <= '0;
         radius_y_ff <= '0;
         cos_ff      <= rmes_pkg::COS_RESET;
         sin_ff      <= rmes_pkg::SIN_RESET;
         pen_ff      <= rmes_pkg::PEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rmes_pkg::CSR_CENTER_X:  center_x_ff <= csr_wdata[COORD_BITS-1:0];
            rmes_pkg::CSR_CENTER_Y:  center_y_ff <= csr_wdata[COORD_BITS-1:0];
            rmes_pkg::CSR_RADIUS_X:  radius_x_ff <= csr_wdata[RADIUS_BITS-1:0];
            rmes_pkg::CSR_RADIUS_Y:  radius_y_ff <= csr_wdata[RADIUS_BITS-1:0];
            rmes_pkg::CSR_COS_Q14:   cos_ff      <= $signed(csr_wdata);
            rmes_pkg::CSR_SIN_Q14:   sin_ff      <= $signed(csr_wdata);
            rmes_pkg::CSR_PEN_WIDTH: pen_ff      <= csr_wdata[rmes_pkg::PEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   rmes_ctrl #(
      .MAX_PEN_WIDTH (MAX_PEN_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_restart (req.restart),
      .req_ready   (req.ready),
      .pen_width   (pen_ff),
      .status      (status),
      .cmd         (cmd)
   );

   rmes_dp #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .center_x         (center_x_ff),
      .center_y         (center_y_ff),
      .radius_x         (radius_x_ff),
      .radius_y         (radius_y_ff),
      .cos_q14          (cos_ff),
      .sin_q14          (sin_ff),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_pixel_x      (rsp.pixel_x),
      .rsp_pixel_y      (rsp.pixel_y),
      .rsp_last_of_step (rsp.last_of_step),
      .rsp_ellipse_done (rsp.ellipse_done)
   );

   // A restart always needs setup cycles before the next word is taken.
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.restart |=> !req.ready)
      else $error("request taken during restart setup");

   // The sequencer only loads the output register when it is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rmes_pkg::OP_LOAD_OUT |-> status.out_free)
      else $error("output word overwritten");

   // No new request is taken while the sequencer is still emitting words.
   a_no_accept_in_copy: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rmes_pkg::OP_LOAD_OUT && !cmd.last |-> !req.ready)
      else $error("request taken mid step");

endmodule

// ===== rtl/rmes_ctrl.sv =====
// Sequencer of the ellipse stepper: phase tracking and one datapath command per cycle.
// Depends on rmes_pkg for states, phases, commands and status.
module rmes_ctrl #(
   parameter int MAX_PEN_WIDTH = rmes_pkg::MAX_PEN_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_restart,
   output logic                          req_ready,
   input  logic [rmes_pkg::PEN_BITS-1:0] pen_width,
   input  rmes_pkg::status_type          status,
   output rmes_pkg::cmd_type             cmd
);

   localparam int MAX_M1 = MAX_PEN_WIDTH - 1;

   rmes_pkg::state_type state_ff, state_in;
   rmes_pkg::phase_type phase_ff, phase_in;
   logic [1:0] mirror_ff, mirror_in;
   logic [rmes_pkg::COPY_BITS-1:0] copy_ff, copy_in;
   logic [rmes_pkg::COPY_BITS-1:0] pw_m1;

   // Pen width minus one, with zero taken as one and large values saturated.
   always_comb begin
      priority if (pen_width == '0) begin
         pw_m1 = '0;
      end else if (pen_width > rmes_pkg::PEN_BITS'(MAX_PEN_WIDTH)) begin
         pw_m1 = rmes_pkg::COPY_BITS'(MAX_M1);
      end else begin
         pw_m1 = rmes_pkg::COPY_BITS'(pen_width - 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rmes_pkg::ST_IDLE;
         phase_ff  <= rmes_pkg::PH_DONE;
         mirror_ff <= '0;
         copy_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         mirror_ff <= mirror_in;
         copy_ff   <= copy_in;
      end
   end

   // Next state and the command for this cycle.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      mirror_in  = mirror_ff;
      copy_in    = copy_ff;
      req_ready  = 1'b0;
      cmd.op     = rmes_pkg::OP_NONE;
      cmd.mirror = mirror_ff;
      cmd.copy   = copy_ff;
      cmd.last   = (mirror_ff == 2'd3) && (copy_ff == pw_m1);
      cmd.done   = (phase_ff == rmes_pkg::PH_DONE);
      unique case (state_ff)
         rmes_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  cmd.op   = rmes_pkg::OP_LATCH;
                  state_in = rmes_pkg::ST_INIT_PROD;
               end else begin
                  case (phase_ff)
                     rmes_pkg::PH_R1: begin
                        cmd.op   = rmes_pkg::OP_R1_MOVE;
                        state_in = rmes_pkg::ST_R1_DEC;
                     end
                     rmes_pkg::PH_R2: begin
                        cmd.op   = rmes_pkg::OP_R2_MOVE;
                        state_in = rmes_pkg::ST_R2_DEC;
                     end
                     default: begin
                        state_in = rmes_pkg::ST_IDLE;
                     end
                  endcase
               end
            end
         end
         rmes_pkg::ST_INIT_PROD: begin
            cmd.op   = rmes_pkg::OP_INIT_PROD;
            state_in = rmes_pkg::ST_INIT_DEC;
         end
         rmes_pkg::ST_INIT_DEC: begin
            cmd.op   = rmes_pkg::OP_INIT_DEC;
            state_in = rmes_pkg::ST_SETTLE;
         end
         rmes_pkg::ST_R1_DEC: begin
            cmd.op   = rmes_pkg::OP_R1_DEC;
            state_in = rmes_pkg::ST_SETTLE;
         end
         rmes_pkg::ST_R2_DEC: begin
            cmd.op   = rmes_pkg::OP_R2_DEC;
            phase_in = status.y_pos ? rmes_pkg::PH_R2 : rmes_pkg::PH_DONE;
            state_in = rmes_pkg::ST_ROT;
         end
         // Stay in region 1 while the x gradient is below the y gradient.
         rmes_pkg::ST_SETTLE: begin
            if (status.px_lt_py) begin
               phase_in = rmes_pkg::PH_R1;
               state_in = rmes_pkg::ST_ROT;
            end else begin
               state_in = rmes_pkg::ST_SQ;
            end
         end
         rmes_pkg::ST_SQ: begin
            cmd.op   = rmes_pkg::OP_SQ;
            state_in = rmes_pkg::ST_PROD2;
         end
         rmes_pkg::ST_PROD2: begin
            cmd.op   = rmes_pkg::OP_PROD2;
            state_in = rmes_pkg::ST_DEC2;
         end
         rmes_pkg::ST_DEC2: begin
            cmd.op   = rmes_pkg::OP_DEC2;
            phase_in = status.y_pos ? rmes_pkg::PH_R2 : rmes_pkg::PH_DONE;
            state_in = rmes_pkg::ST_ROT;
         end
         rmes_pkg::ST_ROT: begin
            cmd.op    = rmes_pkg::OP_ROT;
            mirror_in = '0;
            state_in  = rmes_pkg::ST_MIRROR;
         end
         rmes_pkg::ST_MIRROR: begin
            cmd.op   = rmes_pkg::OP_MIRROR;
            copy_in  = '0;
            state_in = rmes_pkg::ST_COPY;
         end
         // One diagonal copy per cycle while the output register is free.
         rmes_pkg::ST_COPY: begin
            if (status.out_free) begin
               cmd.op = rmes_pkg::OP_LOAD_OUT;
               if (copy_ff == pw_m1) begin
                  if (mirror_ff == 2'd3) begin
                     state_in = rmes_pkg::ST_IDLE;
                  end else begin
                     mirror_in = mirror_ff + 2'd1;
                     state_in  = rmes_pkg::ST_MIRROR;
                  end
               end else begin
                  copy_in = copy_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = rmes_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/rmes_dp.sv =====
// Datapath of the ellipse stepper: iteration registers, rotation and the output word.
// Depends on rmes_pkg for commands and status; driven by rmes_ctrl.
module rmes_dp #(
   parameter int COORD_BITS  = rmes_pkg::COORD_BITS_DEFAULT,
   parameter int RADIUS_BITS = rmes_pkg::RADIUS_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmes_pkg::cmd_type                     cmd,
   output rmes_pkg::status_type                  status,
   input  logic [COORD_BITS-1:0]                 center_x,
   input  logic [COORD_BITS-1:0]                 center_y,
   input  logic [RADIUS_BITS-1:0]                radius_x,
   input  logic [RADIUS_BITS-1:0]                radius_y,
   input  logic signed [rmes_pkg::TRIG_BITS-1:0] cos_q14,
   input  logic signed [rmes_pkg::TRIG_BITS-1:0] sin_q14,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [COORD_BITS-1:0]                 rsp_pixel_x,
   output logic [COORD_BITS-1:0]                 rsp_pixel_y,
   output logic                                  rsp_last_of_step,
   output logic                                  rsp_ellipse_done
);

   localparam int R   = RADIUS_BITS;
   localparam int SQW = 2 * R;          // radius squared
   localparam int XW  = R + 1;          // step x can pass the radius by a little
   localparam int PW  = 3 * R;          // rx^2 * ry
   localparam int AW  = 3 * R + 3;      // gradient accumulators, signed
   localparam int DW  = 4 * R + 4;      // decision, signed
   localparam int T1W = 2 * R + 3;      // x * (x + 1)
   localparam int T2W = 2 * R + 3;      // (y - 1)^2, signed
   localparam int MW  = rmes_pkg::TRIG_BITS + R + 2;
   localparam int SW0 = (COORD_BITS + rmes_pkg::FRAC_BITS + 1 > MW) ?
                        COORD_BITS + rmes_pkg::FRAC_BITS + 1 : MW;
   localparam int SW  = SW0 + 2;
   localparam int BW  = SW - rmes_pkg::FRAC_BITS;
   localparam int VW  = BW + 1;
   localparam int TOP = (1 << COORD_BITS) - 1;

   logic [SQW-1:0]        rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [R-1:0]          y_ff, y_in;
   logic signed [AW-1:0]  px_ff, px_in, py_ff, py_in;
   logic signed [DW-1:0]  dec_ff, dec_in;
   logic                  br_ff, br_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [T1W-1:0]        t1_ff, t1_in;
   logic signed [T2W-1:0] t2_ff, t2_in;
   logic signed [DW-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic signed [MW-1:0]  ma_ff, mb_ff, mc_ff, md_ff;
   logic signed [MW-1:0]  ma_in, mb_in, mc_in, md_in;
   logic signed [BW-1:0]  bx_ff, by_ff, bx_in, by_in;

   logic signed [AW-1:0]  two_rx2, two_ry2, ry2_s, rx2_a;
   logic signed [DW-1:0]  ry2_d, rx2_d, px_d, py_d;
   logic signed [XW:0]    xs;
   logic signed [R:0]     ys, ym;
   logic signed [T2W:0]   t2_less;
   logic signed [SW-1:0]  sum_x, sum_y, term_a, term_b, term_c, term_d;
   logic signed [VW-1:0]  vx, vy;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                  out_last_ff, out_done_ff, out_last_in, out_done_in;

   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [VW-1:0] v);
      logic [COORD_BITS-1:0] res;
      begin
         priority if (v < 0) begin
            res = '0;
         end else if (v > VW'(TOP)) begin
            res = COORD_BITS'(TOP);
         end else begin
            res = v[COORD_BITS-1:0];
         end
         return res;
      end
   endfunction

   // Signed views of the squared radii and gradients.
   always_comb begin
      rx2_a   = AW'($signed({1'b0, rx2_ff}));
      ry2_s   = AW'($signed({1'b0, ry2_ff}));
      two_rx2 = rx2_a <<< 1;
      two_ry2 = ry2_s <<< 1;
      rx2_d   = DW'($signed({1'b0, rx2_ff}));
      ry2_d   = DW'($signed({1'b0, ry2_ff}));
      px_d    = DW'(px_ff);
      py_d    = DW'(py_ff);
      xs      = $signed({1'b0, x_ff});
      ys      = $signed({1'b0, y_ff});
      ym      = ys - (R+1)'(1);
      t2_less = (T2W+1)'(t2_ff) - (T2W+1)'($signed({1'b0, ry2_ff}));
   end

   // Mirrored rotation sums for the current quadrant, rounded half up.
   always_comb begin
      term_a = cmd.mirror[0] ? -SW'(ma_ff) : SW'(ma_ff);
      term_b = cmd.mirror[1] ? -SW'(mb_ff) : SW'(mb_ff);
      term_c = cmd.mirror[0] ? -SW'(mc_ff) : SW'(mc_ff);
      term_d = cmd.mirror[1] ? -SW'(md_ff) : SW'(md_ff);
      sum_x  = SW'($signed({1'b0, center_x, {rmes_pkg::FRAC_BITS{1'b0}}})) + term_a - term_b
               + SW'(rmes_pkg::ROUND_HALF);
      sum_y  = SW'($signed({1'b0, center_y, {rmes_pkg::FRAC_BITS{1'b0}}})) + term_c + term_d
               + SW'(rmes_pkg::ROUND_HALF);
      vx     = VW'(bx_ff) + VW'($signed({1'b0, cmd.copy}));
      vy     = VW'(by_ff) - VW'($signed({1'b0, cmd.copy}));
   end

   // Next values of the iteration and rotation registers.
   always_comb begin
      rx2_in = rx2_ff;
      ry2_in = ry2_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      px_in  = px_ff;
      py_in  = py_ff;
      dec_in = dec_ff;
      br_in  = br_ff;
      prod_in = prod_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      p1_in  = p1_ff;
      p2_in  = p2_ff;
      ma_in  = ma_ff;
      mb_in  = mb_ff;
      mc_in  = mc_ff;
      md_in  = md_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      unique case (cmd.op)
         rmes_pkg::OP_LATCH: begin
            rx2_in = SQW'(radius_x) * SQW'(radius_x);
            ry2_in = SQW'(radius_y) * SQW'(radius_y);
            x_in   = '0;
            y_in   = radius_y;
            px_in  = '0;
         end
         rmes_pkg::OP_INIT_PROD: begin
            prod_in = PW'(rx2_ff) * PW'(y_ff);
         end
         rmes_pkg::OP_INIT_DEC: begin
            py_in  = AW'($signed({1'b0, prod_ff, 1'b0}));
            dec_in = ry2_d - DW'($signed({1'b0, prod_ff})) + (rx2_d >>> 2);
         end
         rmes_pkg::OP_R1_MOVE: begin
            x_in  = x_ff + 1'b1;
            px_in = px_ff + two_ry2;
            br_in = dec_ff < 0;
            if (dec_ff >= 0) begin
               y_in  = y_ff - 1'b1;
               py_in = py_ff - two_rx2;
            end
         end
         rmes_pkg::OP_R1_DEC: begin
            dec_in = dec_ff + ry2_d + px_d - (br_ff ? DW'(0) : py_d);
         end
         rmes_pkg::OP_R2_MOVE: begin
            y_in  = y_ff - 1'b1;
            py_in = py_ff - two_rx2;
            br_in = dec_ff > 0;
            if (dec_ff <= 0) begin
               x_in  = x_ff + 1'b1;
               px_in = px_ff + two_ry2;
            end
         end
         rmes_pkg::OP_R2_DEC: begin
            dec_in = dec_ff + rx2_d - py_d + (br_ff ? DW'(0) : px_d);
         end
         rmes_pkg::OP_SQ: begin
            t1_in = T1W'(x_ff) * (T1W'(x_ff) + T1W'(1));
            t2_in = T2W'(ym) * T2W'(ym);
         end
         rmes_pkg::OP_PROD2: begin
            p1_in = DW'($signed({1'b0, ry2_ff})) * DW'($signed({1'b0, t1_ff}));
            p2_in = DW'($signed({1'b0, rx2_ff})) * DW'(t2_less);
         end
         rmes_pkg::OP_DEC2: begin
            dec_in = p1_ff + p2_ff + (ry2_d >>> 2);
         end
         rmes_pkg::OP_ROT: begin
            ma_in = MW'(cos_q14) * MW'(xs);
            mb_in = MW'(sin_q14) * MW'(ys);
            mc_in = MW'(sin_q14) * MW'(xs);
            md_in = MW'(cos_q14) * MW'(ys);
         end
         rmes_pkg::OP_MIRROR: begin
            bx_in = sum_x[SW-1:rmes_pkg::FRAC_BITS];
            by_in = sum_y[SW-1:rmes_pkg::FRAC_BITS];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx2_ff <= '0;
         ry2_ff <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
         px_ff  <= '0;
         py_ff  <= '0;
         dec_ff <= '0;
      end else begin
         rx2_ff <= rx2_in;
         ry2_ff <= ry2_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         dec_ff <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      br_ff   <= br_in;
      prod_ff <= prod_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      mc_ff   <= mc_in;
      md_ff   <= md_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
   end

   // Output register: loaded with one clamped diagonal copy, emptied by the sink.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (cmd.op == rmes_pkg::OP_LOAD_OUT) begin
         out_valid_in = 1'b1;
         out_x_in     = clamp_coord(vx);
         out_y_in     = clamp_coord(vy);
         out_last_in  = cmd.last;
         out_done_in  = cmd.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign status.px_lt_py = px_ff < py_ff;
   assign status.y_pos    = y_ff != '0;
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_last_of_step = out_last_ff;
   assign rsp_ellipse_done = out_done_ff;

endmodule
